/* hdl/pvm_pkg.sv */
// Shared types and constants for the PCM voice mixer.
// No dependencies; pvm_mac, pcm_voice_mixer_top and pvm_checker import this package.
package pvm_pkg;

  localparam int VOICES_DEFAULT       = 8;
  localparam int SAMPLE_WORDS_DEFAULT = 65536;

  // Fixed-point layout: 17.16 positions, 8.8 gains.
  localparam int POS_FRAC  = 16;
  localparam int POS_W     = 33;
  localparam int GAIN_FRAC = 8;
  localparam int ACC_W     = 32;
  localparam logic signed [ACC_W-1:0] CLIP_HI = 32'sd32767;
  localparam logic signed [ACC_W-1:0] CLIP_LO = -32'sd32767;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_COMMAND = 2'd1,
    OP_RENDER  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    FMT_MONO8    = 2'd0,
    FMT_STEREO8  = 2'd1,
    FMT_MONO16   = 2'd2,
    FMT_STEREO16 = 2'd3
  } fmt_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_EVAL,
    ST_LMUL,
    ST_LACC,
    ST_RACC,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [15:0] base;
    logic [15:0] frames;
    fmt_t        kind;
  } wave_t;

  typedef struct packed {
    logic [15:0] gain;
    logic [31:0] step;
    logic        loop;
  } vctrl_t;

  typedef struct packed {
    logic load;
    logic byte_mode;
  } mac_ctrl_t;

endpackage

/* hdl/pvm_if.sv */
// Request and result channel interfaces of the PCM voice mixer.
// Stand-alone; valid/ready handshake with the payload fields of each word.
interface pvm_req_if;
  logic              valid;
  logic              ready;
  logic [1:0]        operation;
  logic [15:0]       mem_address;
  logic signed [15:0] mem_word;
  logic [2:0]        voice;
  logic [15:0]       wave_start;
  logic [15:0]       wave_frames;
  logic [1:0]        wave_format;
  logic [15:0]       gain;
  logic [31:0]       step;
  logic              loop_enable;
  logic              retrigger;

  modport source (
    output valid, operation, mem_address, mem_word, voice, wave_start, wave_frames,
           wave_format, gain, step, loop_enable, retrigger,
    input  ready
  );
  modport sink (
    input  valid, operation, mem_address, mem_word, voice, wave_start, wave_frames,
           wave_format, gain, step, loop_enable, retrigger,
    output ready
  );
endinterface

interface pvm_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] left_sample;
  logic signed [15:0] right_sample;

  modport source (output valid, left_sample, right_sample, input ready);
  modport sink (input valid, left_sample, right_sample, output ready);
endinterface

/* hdl/pvm_mac.sv */
// Shared sample-by-gain multiplier with its product register and scaling.
// Depends on pvm_pkg.
module pvm_mac import pvm_pkg::*; (
  input  logic                    clk,
  input  mac_ctrl_t               ctrl,
  input  logic [15:0]             sample,
  input  logic [15:0]             gain,
  output logic signed [ACC_W-1:0] contrib
);

  logic signed [16:0] sample_s;
  logic signed [16:0] gain_s;
  logic signed [33:0] prod;
  logic               byte_mode;
  logic [15:0]        quot;

  always_comb begin
    if (ctrl.byte_mode) begin
      sample_s = $signed({{9{sample[7]}}, sample[7:0]});
    end else begin
      sample_s = $signed({sample[15], sample});
    end
    gain_s = $signed({1'b0, gain});
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      prod      <= sample_s * gain_s;
      byte_mode <= ctrl.byte_mode;
    end
  end

  // Divide by 256 toward zero: a negative product with a nonzero fraction rounds up by one.
  assign quot = prod[GAIN_FRAC+15:GAIN_FRAC]
              + 16'(prod[33] && (prod[GAIN_FRAC-1:0] != '0));

  assign contrib = byte_mode ? $signed(prod[ACC_W-1:0]) : ACC_W'($signed(quot));

endmodule

/* hdl/pcm_voice_mixer_top.sv */
// Top level of the PCM voice mixer: sample memory, voice tables, sequencer and mixer.
// Depends on pvm_pkg, pvm_if (pvm_req_if, pvm_rsp_if) and pvm_mac.
//
//   Channel | Direction | Payload                                   | Words
//   --------+-----------+-------------------------------------------+---------------------
//   req     | in        | operation, memory load, voice command     | load, command, render
//   rsp     | out       | left_sample, right_sample                 | one per render
//
// Loads and voice commands are taken while idle and produce no word.
// A render walks the voice slots one after another: an inactive slot passes FETCH
// only, a playing voice goes through FETCH, EVAL, LMUL and LACC and a 16-bit stereo
// voice also through RACC, all through the one shared multiplier and the single
// sample memory read port; DONE then clips and hands over the frame.
// Reset clears the sequencer, the voice active flags and the result register; the
// sample memory and the voice tables hold no reset value and need no clearing pass.
// The request side stays open while a finished frame waits on the result register;
// only a render that completes before that frame is taken waits for it.
// SAMPLE_WORDS must be a power of two, so that addresses wrap by truncation.
module pcm_voice_mixer_top import pvm_pkg::*; #(
  parameter int VOICES       = VOICES_DEFAULT,
  parameter int SAMPLE_WORDS = SAMPLE_WORDS_DEFAULT
) (
  input logic      clk,
  input logic      rst,
  pvm_req_if.sink  req,
  pvm_rsp_if.source rsp
);

  localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int AW = $clog2(SAMPLE_WORDS);

  // Symmetric clip of a mixed sum to the 16-bit output range.
  function automatic logic signed [15:0] clip16(input logic signed [ACC_W-1:0] x);
    logic signed [ACC_W-1:0] y;
    if (x > CLIP_HI) begin
      y = CLIP_HI;
    end else if (x < CLIP_LO) begin
      y = CLIP_LO;
    end else begin
      y = x;
    end
    return y[15:0];
  endfunction

  // Storage. Only the active flags carry a reset; the voice table entries of a voice are
  // written when it is started, before a render can look at them.
  logic [15:0]      sample_store [SAMPLE_WORDS];
  wave_t            voice_wave   [VOICES];
  vctrl_t           voice_ctrl   [VOICES];
  logic [POS_W-1:0] voice_pos    [VOICES];
  logic [VOICES-1:0] voice_active;

  // Sequencer registers.
  state_t                  state, state_next;
  logic [VW-1:0]           idx, idx_next;
  logic signed [ACC_W-1:0] acc_l, acc_l_next;
  logic signed [ACC_W-1:0] acc_r, acc_r_next;
  logic [POS_W-1:0]        work_pos, work_pos_next;
  logic [AW-1:0]           addr_r, addr_r_next;
  logic                    out_valid;
  logic signed [15:0]      out_left, out_right;

  // Registered memory read data.
  logic [15:0]      rd_data;
  wave_t            wave_q;
  vctrl_t           ctrl_q;
  logic [POS_W-1:0] pos_q;

  // Control produced by the sequencer.
  logic             req_ready;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [AW-1:0]    rd_addr;
  logic             wave_we, ctrl_we, pos_we;
  logic [VW-1:0]    cmd_idx;
  logic [VW-1:0]    pos_waddr;
  logic [POS_W-1:0] pos_wdata;
  logic             act_set, act_clr;
  logic [VW-1:0]    act_idx;
  logic             out_load;
  mac_ctrl_t        mac_ctrl;
  logic signed [ACC_W-1:0] contrib;

  // Evaluation helpers for the voice under the cursor.
  logic             last_voice;
  logic             ended;
  logic [POS_W-1:0] eff_pos;
  logic [15:0]      frame;
  logic [17:0]      addr_sum;
  logic [AW-1:0]    addr_l;
  logic             accept;
  logic             cmd_ok;

  assign accept     = req.valid && req_ready;
  assign cmd_ok     = int'(req.voice) < VOICES;
  assign cmd_idx    = VW'(req.voice);
  assign last_voice = (idx == VW'(VOICES - 1));
  assign mem_waddr  = AW'(req.mem_address);

  // A voice has ended once its position reaches frames << 16; a looping voice then
  // plays from frame zero within the same render.
  assign ended   = pos_q >= {1'b0, wave_q.frames, 16'b0};
  assign eff_pos = ended ? '0 : pos_q;
  assign frame   = eff_pos[POS_FRAC+15:POS_FRAC];
  assign addr_sum = 18'(wave_q.base)
                  + ((wave_q.kind == FMT_STEREO16) ? {1'b0, frame, 1'b0} : 18'(frame));
  assign addr_l  = AW'(addr_sum);

  pvm_mac u_mac (
    .clk     (clk),
    .ctrl    (mac_ctrl),
    .sample  (rd_data),
    .gain    (ctrl_q.gain),
    .contrib (contrib)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    idx_next      = idx;
    acc_l_next    = acc_l;
    acc_r_next    = acc_r;
    work_pos_next = work_pos;
    addr_r_next   = addr_r;
    req_ready     = 1'b0;
    mem_we        = 1'b0;
    rd_addr       = addr_l;
    wave_we       = 1'b0;
    ctrl_we       = 1'b0;
    pos_we        = 1'b0;
    pos_waddr     = idx;
    pos_wdata     = '0;
    act_set       = 1'b0;
    act_clr       = 1'b0;
    act_idx       = idx;
    out_load      = 1'b0;
    mac_ctrl      = '{load: 1'b0, byte_mode: 1'b0};

    unique case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        idx_next  = '0;
        if (accept) begin
          case (req.operation)
            OP_LOAD: begin
              mem_we = 1'b1;
            end
            OP_COMMAND: begin
              act_idx   = cmd_idx;
              pos_waddr = cmd_idx;
              if (cmd_ok) begin
                if (req.gain == '0) begin
                  act_clr = 1'b1;
                end else begin
                  ctrl_we = 1'b1;
                  if (!voice_active[cmd_idx]) begin
                    act_set = 1'b1;
                    wave_we = 1'b1;
                    pos_we  = 1'b1;
                  end else if (req.retrigger) begin
                    pos_we = 1'b1;
                  end
                end
              end
            end
            OP_RENDER: begin
              acc_l_next = '0;
              acc_r_next = '0;
              state_next = ST_FETCH;
            end
            default: begin
            end
          endcase
        end
      end

      ST_FETCH: begin
        if (voice_active[idx]) begin
          state_next = ST_EVAL;
        end else if (last_voice) begin
          state_next = ST_DONE;
        end else begin
          idx_next = idx + 1'b1;
        end
      end

      ST_EVAL: begin
        work_pos_next = eff_pos;
        addr_r_next   = addr_l + 1'b1;
        if (wave_q.kind == FMT_STEREO8) begin
          // 8-bit stereo is not played: the voice drops out on its first render.
          act_clr = 1'b1;
        end else if (ended && (!ctrl_q.loop || wave_q.frames == '0)) begin
          // A looping empty wave parks at zero; a finished one-shot voice stays silent.
          pos_we    = ctrl_q.loop;
          pos_wdata = '0;
        end else begin
          state_next = ST_LMUL;
        end
        if (state_next == ST_EVAL) begin
          state_next = last_voice ? ST_DONE : ST_FETCH;
          idx_next   = last_voice ? idx : idx + 1'b1;
        end
      end

      ST_LMUL: begin
        rd_addr    = addr_r;
        mac_ctrl   = '{load: 1'b1, byte_mode: (wave_q.kind == FMT_MONO8)};
        state_next = ST_LACC;
      end

      ST_LACC: begin
        acc_l_next = acc_l + contrib;
        if (wave_q.kind == FMT_STEREO16) begin
          mac_ctrl   = '{load: 1'b1, byte_mode: 1'b0};
          state_next = ST_RACC;
        end else begin
          acc_r_next = acc_r + contrib;
          pos_we     = 1'b1;
          pos_wdata  = work_pos + POS_W'(ctrl_q.step);
          state_next = last_voice ? ST_DONE : ST_FETCH;
          idx_next   = last_voice ? idx : idx + 1'b1;
        end
      end

      ST_RACC: begin
        acc_r_next = acc_r + contrib;
        pos_we     = 1'b1;
        pos_wdata  = work_pos + POS_W'(ctrl_q.step);
        state_next = last_voice ? ST_DONE : ST_FETCH;
        idx_next   = last_voice ? idx : idx + 1'b1;
      end

      ST_DONE: begin
        if (!out_valid || rsp.ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    idx      <= idx_next;
    acc_l    <= acc_l_next;
    acc_r    <= acc_r_next;
    work_pos <= work_pos_next;
    addr_r   <= addr_r_next;
  end

  // Sample memory: one write port for loads, one registered read port for renders.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      sample_store[mem_waddr] <= req.mem_word;
    end
    rd_data <= sample_store[rd_addr];
  end

  // Voice tables, read at the render cursor.
  always_ff @(posedge clk) begin
    if (wave_we) begin
      voice_wave[cmd_idx] <= '{base: req.wave_start, frames: req.wave_frames,
                               kind: fmt_t'(req.wave_format)};
    end
    if (ctrl_we) begin
      voice_ctrl[cmd_idx] <= '{gain: req.gain, step: req.step, loop: req.loop_enable};
    end
    if (pos_we) begin
      voice_pos[pos_waddr] <= pos_wdata;
    end
    wave_q <= voice_wave[idx];
    ctrl_q <= voice_ctrl[idx];
    pos_q  <= voice_pos[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      voice_active <= '0;
    end else begin
      if (act_clr) begin
        voice_active[act_idx] <= 1'b0;
      end
      if (act_set) begin
        voice_active[act_idx] <= 1'b1;
      end
    end
  end

  // Result register decouples the mixer from the consumer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_left  <= clip16(acc_l);
      out_right <= clip16(acc_r);
    end
  end

  assign req.ready        = req_ready;
  assign rsp.valid        = out_valid;
  assign rsp.left_sample  = out_left;
  assign rsp.right_sample = out_right;

endmodule

/* hdl/pvm_checker.sv */
// Port-level checks for the PCM voice mixer, bound to its top level.
// Depends on pvm_pkg and pcm_voice_mixer_top.
module pvm_checker import pvm_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_ready,
  input logic [1:0]        req_operation,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input logic signed [15:0] left_sample,
  input logic signed [15:0] right_sample
);

  // The mixed samples are clipped symmetrically, so the most negative code never shows.
  a_clip_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (left_sample != 16'sh8000) && (right_sample != 16'sh8000))
    else $error("mixed sample outside the symmetric clip range");

  // A render occupies the sequencer, so the request side closes right after it.
  a_render_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && (req_operation == OP_RENDER) |=> !req_ready)
    else $error("request taken while a render was in progress");

  // A new frame only appears right after the mixer was busy.
  a_frame_after_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(!req_ready))
    else $error("result word appeared without a render");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result word valid after reset");

  // A waiting result word holds still.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(left_sample) && $stable(right_sample))
    else $error("stalled result word changed");

endmodule

bind pcm_voice_mixer_top pvm_checker u_pvm_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .req_operation (req.operation),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .left_sample   (rsp.left_sample),
  .right_sample  (rsp.right_sample)
);
